@@ design/mdc1200_frame_encoder_macros.svh @@
// Assertion macros used by the frame encoder's serializer.
`ifndef MDC1200_FRAME_ENCODER_MACROS_SVH
`define MDC1200_FRAME_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
// Checked from reset release onwards.
`define MDC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MDC_ASSERT(label, clk, rst_n, prop, msg)
`define MDC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ design/mdc_pkg.sv @@
package mdc_pkg;

  localparam int WORD_COUNT   = 13;
  localparam int HEAD_WORDS   = 6;
  localparam int PL_WORDS     = WORD_COUNT - HEAD_WORDS;
  localparam int PL_BYTES     = 2 * PL_WORDS;
  localparam int PARITY_BYTES = 7;
  localparam int IDX_W        = 4;

  localparam logic [15:0]      CRC_POLY   = 16'h1021;
  localparam logic [15:0]      CRC_XOROUT = 16'hFFFF;
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WORD_COUNT - 1);

  // Preamble and sync, packed two bytes to a word.
  localparam logic [HEAD_WORDS-1:0][15:0] HEAD_WORD = '{
    16'h446F, 16'h092A, 16'h5507, 16'h5555, 16'h5555, 16'h5555
  };

  typedef struct packed {
    logic [7:0]  op_code;
    logic [7:0]  argument;
    logic [15:0] unit_id;
  } item_t;

  // Intake stage towards the payload builder.
  typedef struct packed {
    logic        valid;
    item_t       item;
    logic [15:0] crc_part;
  } stage_t;

  typedef logic [PL_WORDS-1:0][15:0] pl_words_t;

  // Eight CRC steps, data byte taken LSB first (reflected input).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int j = 0; j < 8; j++) begin
      fb = c[15] ^ d[j];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [15:0] reflect16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

endpackage

@@ design/mdc_intake.sv @@
module mdc_intake (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mdc_pkg::item_t item,
  input  logic           advance,
  output logic           busy,
  output mdc_pkg::stage_t stage
);
  import mdc_pkg::*;

  logic        valid_r, valid_nxt;
  item_t       item_r;
  logic [15:0] crc_r;
  logic        accept;

  assign busy   = valid_r && !advance;
  assign accept = start && !busy;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // First half of the CRC is worked out on the way in.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
      crc_r  <= crc_byte(crc_byte(16'h0000, item.op_code), item.argument);
    end
  end

  assign stage.valid    = valid_r;
  assign stage.item     = item_r;
  assign stage.crc_part = crc_r;

endmodule

@@ design/mdc_payload.sv @@
module mdc_payload (
  input  mdc_pkg::stage_t   stage,
  output mdc_pkg::pl_words_t words
);
  import mdc_pkg::*;

  localparam int STREAM_BITS = 8 * PARITY_BYTES;

  logic [15:0] crc;
  logic [7:0]  src [PL_BYTES];
  logic        x   [STREAM_BITS];
  logic        par [STREAM_BITS];

  assign crc = reflect16(crc_byte(crc_byte(stage.crc_part, stage.item.unit_id[15:8]),
                                  stage.item.unit_id[7:0])) ^ CRC_XOROUT;

  always_comb begin
    src[0] = stage.item.op_code;
    src[1] = stage.item.argument;
    src[2] = stage.item.unit_id[15:8];
    src[3] = stage.item.unit_id[7:0];
    src[4] = crc[7:0];
    src[5] = crc[15:8];
    src[6] = 8'h00;
    // Feed the first seven bytes LSB first through the K=7 coder.
    for (int t = 0; t < STREAM_BITS; t++) begin
      x[t] = src[t/8][t%8];
    end
    for (int t = 0; t < STREAM_BITS; t++) begin
      par[t] = x[t];
      if (t >= 2) par[t] = par[t] ^ x[t-2];
      if (t >= 5) par[t] = par[t] ^ x[t-5];
      if (t >= 6) par[t] = par[t] ^ x[t-6];
    end
    for (int i = 0; i < PARITY_BYTES; i++) begin
      for (int j = 0; j < 8; j++) begin
        src[PARITY_BYTES+i][j] = par[8*i+j];
      end
    end
  end

  // Interleave: word k, bit j from the MSB holds source bit 7j + k.
  always_comb begin
    for (int k = 0; k < PL_WORDS; k++) begin
      for (int j = 0; j < 16; j++) begin
        words[k][15-j] = src[(7*j+k)/8][7-((7*j+k)%8)];
      end
    end
  end

endmodule

@@ design/mdc_serializer.sv @@
`include "mdc1200_frame_encoder_macros.svh"

module mdc_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  mdc_pkg::pl_words_t words,
  output logic               ready,
  output logic               strobe,
  output logic [15:0]        fifo_word,
  output logic [3:0]         word_index,
  output logic               last_word
);
  import mdc_pkg::*;

  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] count_inc;
  pl_words_t        pl_r;
  logic             finishing;
  logic [IDX_W-1:0] off;

  assign finishing = valid_r && (count_r == LAST_IDX);
  assign ready     = !valid_r || finishing;
  assign count_inc = count_r + 1'b1;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    priority if (load) begin
      valid_nxt = 1'b1;
      count_nxt = '0;
    end else if (finishing) begin
      valid_nxt = 1'b0;
    end else if (valid_r) begin
      count_nxt = count_inc;
    end else begin
      // hold while idle
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pl_r <= words;
    end
  end

  assign off = count_r - IDX_W'(HEAD_WORDS);

  always_comb begin
    if (count_r < IDX_W'(HEAD_WORDS)) begin
      fifo_word = HEAD_WORD[count_r[2:0]];
    end else begin
      fifo_word = pl_r[off[2:0]];
    end
  end

  assign strobe     = valid_r;
  assign word_index = count_r;
  assign last_word  = finishing;

  `MDC_ASSERT(a_count_range, clk, rst_n, !valid_r || count_r <= LAST_IDX, "word index out of range")
  `MDC_ASSERT(a_load_only_ready, clk, rst_n, load |-> ready, "frame loaded over a running one")
  `MDC_ASSERT(a_gapless, clk, rst_n, !ready |=> valid_r && count_r == $past(count_inc), "frame gap")
  `MDC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !strobe, "strobe after reset")

endmodule

@@ design/mdc1200_frame_encoder.sv @@
// Single-burst frame encoder. Each accepted request (start high while busy is
// low) yields a 26-byte frame as thirteen 16-bit words on consecutive cycles,
// each marked by out_strobe for one cycle, out_last_word on the thirteenth.
// The receiver cannot stall: it must take a word on every strobe. A request
// passes the intake register, then the serializer registers, before its first
// word is driven. One request can wait in the intake register while a frame is
// being sent, so back-to-back requests give gap-free output from the output
// serializer, which sends one word per cycle.
module mdc1200_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_op_code,
  input  logic [7:0]  in_argument,
  input  logic [15:0] in_unit_id,
  output logic        out_strobe,
  output logic [15:0] out_fifo_word,
  output logic [3:0]  out_word_index,
  output logic        out_last_word
);
  import mdc_pkg::*;

  item_t     item;
  stage_t    stage;
  pl_words_t words;
  logic      ser_ready;
  logic      load;

  assign item.op_code  = in_op_code;
  assign item.argument = in_argument;
  assign item.unit_id  = in_unit_id;

  // Hand the waiting request over as soon as the serializer frees up.
  assign load = stage.valid && ser_ready;

  mdc_intake u_intake (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .item    (item),
    .advance (load),
    .busy    (busy),
    .stage   (stage)
  );

  mdc_payload u_payload (
    .stage (stage),
    .words (words)
  );

  mdc_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .words      (words),
    .ready      (ser_ready),
    .strobe     (out_strobe),
    .fifo_word  (out_fifo_word),
    .word_index (out_word_index),
    .last_word  (out_last_word)
  );

endmodule
